>>> design/dhcprp_pkg.sv
// Shared types and constants for the DHCP reply parser.
// Used by dhcprp_parse and dhcp_reply_parser_unit; no dependencies.
package dhcprp_pkg;

  // Bytes at this position and beyond are not parsed (1024 .. 65535).
  localparam int unsigned MAX_PACKET_BYTES = 1024;

  localparam int POS_W     = 16;
  localparam int NUM_SLOTS = 6;

  localparam logic [POS_W-1:0] POS_OP        = 16'd0;
  localparam logic [POS_W-1:0] POS_XID_LO    = 16'd4;
  localparam logic [POS_W-1:0] POS_XID_HI    = 16'd7;
  localparam logic [POS_W-1:0] POS_YIADDR_LO = 16'd16;
  localparam logic [POS_W-1:0] POS_YIADDR_HI = 16'd19;
  localparam logic [POS_W-1:0] POS_MSGTYPE   = 16'd240;
  localparam logic [POS_W-1:0] POS_MSGVAL    = 16'd242;
  localparam logic [POS_W-1:0] POS_MAX       = 16'hFFFF;
  // Last byte at this position or later gives at least 243 bytes.
  localparam logic [POS_W-1:0] POS_MIN_LAST  = 16'd242;

  localparam logic [7:0] BOOTREPLY   = 8'd2;
  localparam logic [7:0] TYPE_OFFER  = 8'd2;
  localparam logic [7:0] TYPE_ACK    = 8'd5;
  localparam logic [7:0] OPT_PAD     = 8'd0;
  localparam logic [7:0] OPT_MASK    = 8'd1;
  localparam logic [7:0] OPT_ROUTER  = 8'd3;
  localparam logic [7:0] OPT_DNS     = 8'd6;
  localparam logic [7:0] OPT_LEASE   = 8'd51;
  localparam logic [7:0] OPT_MSGTYPE = 8'd53;
  localparam logic [7:0] OPT_SERVER  = 8'd54;
  localparam logic [7:0] OPT_END     = 8'd255;

  localparam logic [2:0] ADDR_BYTES = 3'd4;

  localparam logic [2:0] SLOT_IP     = 3'd0;
  localparam logic [2:0] SLOT_MASK   = 3'd1;
  localparam logic [2:0] SLOT_GW     = 3'd2;
  localparam logic [2:0] SLOT_DNS    = 3'd3;
  localparam logic [2:0] SLOT_SERVER = 3'd4;
  localparam logic [2:0] SLOT_LEASE  = 3'd5;

  typedef enum logic [1:0] {
    PHASE_CODE  = 2'd0,
    PHASE_LEN   = 2'd1,
    PHASE_VALUE = 2'd2,
    PHASE_DONE  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    KIND_NONE      = 2'd0,
    KIND_OFFER     = 2'd1,
    KIND_ACK       = 2'd2,
    KIND_TYPE_SEEN = 2'd3
  } kind_t;

  typedef logic [NUM_SLOTS-1:0][31:0] slot_vals_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    logic [1:0]  message_kind;
    logic        bound;
    logic [31:0] offered_ip;
    logic [31:0] subnet_mask;
    logic [31:0] gateway_ip;
    logic [31:0] dns_ip;
    logic [31:0] server_ip;
    logic [31:0] lease_seconds;
  } out_item_t;

  // Per-packet parse state.
  typedef struct packed {
    logic [POS_W-1:0]     byte_position;
    logic                 header_match;
    logic [31:0]          xid_shift;
    kind_t                kind_seen;
    phase_t               option_phase;
    logic [7:0]           option_code;
    logic [7:0]           option_remaining;
    logic [2:0]           option_offset;
    logic [31:0]          value_shift;
    slot_vals_t           pending_values;
    logic [NUM_SLOTS-1:0] pending_valid;
  } parse_state_t;

  localparam parse_state_t PARSE_RESET = '{
    byte_position:    '0,
    header_match:     1'b1,
    xid_shift:        '0,
    kind_seen:        KIND_NONE,
    option_phase:     PHASE_CODE,
    option_code:      '0,
    option_remaining: '0,
    option_offset:    '0,
    value_shift:      '0,
    pending_values:   '0,
    pending_valid:    '0
  };

endpackage

>>> design/dhcprp_parse.sv
// Next-state logic of the reply parser for one payload byte.
// Depends on dhcprp_pkg.
module dhcprp_parse import dhcprp_pkg::*; (
  input  parse_state_t cur,
  input  logic [7:0]   payload_byte,
  input  logic [31:0]  transaction_id,
  output parse_state_t nxt,
  output kind_t        reply_kind
);

  logic [POS_W-1:0] pos;
  logic [31:0]      xid_new;
  logic [31:0]      val_new;
  logic [2:0]       off_new;
  logic [7:0]       rem_new;
  logic             slot_hit;
  logic [2:0]       slot_idx;

  assign pos = cur.byte_position;

  // Map caught option codes to their slots.
  always_comb begin
    slot_hit = 1'b1;
    slot_idx = SLOT_MASK;
    case (cur.option_code)
      OPT_MASK:   slot_idx = SLOT_MASK;
      OPT_ROUTER: slot_idx = SLOT_GW;
      OPT_DNS:    slot_idx = SLOT_DNS;
      OPT_SERVER: slot_idx = SLOT_SERVER;
      OPT_LEASE:  slot_idx = SLOT_LEASE;
      default:    slot_hit = 1'b0;
    endcase
  end

  always_comb begin
    nxt     = cur;
    xid_new = {cur.xid_shift[23:0], payload_byte};
    val_new = {cur.value_shift[23:0], payload_byte};
    off_new = cur.option_offset + 3'd1;
    rem_new = cur.option_remaining - 8'd1;

    if (pos < POS_W'(MAX_PACKET_BYTES)) begin
      if (pos == POS_OP && payload_byte != BOOTREPLY) begin
        nxt.header_match = 1'b0;
      end
      if (pos inside {[POS_XID_LO:POS_XID_HI]}) begin
        nxt.xid_shift = xid_new;
        if (pos == POS_XID_HI && xid_new != transaction_id) begin
          nxt.header_match = 1'b0;
        end
      end
      // Assemble yiaddr big-endian.
      if (pos inside {[POS_YIADDR_LO:POS_YIADDR_HI]}) begin
        nxt.value_shift = val_new;
        if (pos == POS_YIADDR_HI) begin
          nxt.pending_values[SLOT_IP] = val_new;
          nxt.pending_valid[SLOT_IP]  = 1'b1;
        end
      end
      if (pos == POS_MSGTYPE) begin
        nxt.kind_seen = (payload_byte == OPT_MSGTYPE) ? KIND_TYPE_SEEN : KIND_NONE;
      end
      if (pos == POS_MSGVAL && cur.kind_seen == KIND_TYPE_SEEN) begin
        nxt.kind_seen = (payload_byte == TYPE_OFFER) ? KIND_OFFER :
                        (payload_byte == TYPE_ACK)   ? KIND_ACK   : KIND_NONE;
      end
      // Option walk from the message type option onward.
      if (pos >= POS_MSGTYPE) begin
        case (cur.option_phase)
          PHASE_CODE: begin
            if (payload_byte == OPT_END) begin
              nxt.option_phase = PHASE_DONE;
            end else if (payload_byte != OPT_PAD) begin
              nxt.option_code  = payload_byte;
              nxt.option_phase = PHASE_LEN;
            end
          end
          PHASE_LEN: begin
            nxt.option_remaining = payload_byte;
            nxt.option_offset    = '0;
            nxt.value_shift      = '0;
            nxt.option_phase     = (payload_byte != 8'd0) ? PHASE_VALUE : PHASE_CODE;
          end
          PHASE_VALUE: begin
            if (cur.option_offset < ADDR_BYTES) begin
              nxt.value_shift   = val_new;
              nxt.option_offset = off_new;
              if (off_new == ADDR_BYTES && slot_hit) begin
                nxt.pending_values[slot_idx] = val_new;
                nxt.pending_valid[slot_idx]  = 1'b1;
              end
            end
            nxt.option_remaining = rem_new;
            if (rem_new == 8'd0) begin
              nxt.option_phase = PHASE_CODE;
            end
          end
          default: ;
        endcase
      end
    end

    if (pos != POS_MAX) begin
      nxt.byte_position = pos + 16'd1;
    end
  end

  // Verdict if this byte closes the packet.
  always_comb begin
    reply_kind = KIND_NONE;
    if (pos >= POS_MIN_LAST && nxt.header_match &&
        (nxt.kind_seen == KIND_OFFER || nxt.kind_seen == KIND_ACK)) begin
      reply_kind = nxt.kind_seen;
    end
  end

endmodule

>>> design/dhcp_reply_parser_unit.sv
// Top level of the DHCP client reply parser: byte handshake, parse state,
// stored lease values and a two-entry result buffer. Depends on dhcprp_pkg
// and dhcprp_parse.
//
// The unit takes one payload byte per clock, starting at the BOOTP op
// field, with last_byte set on the final byte. Each byte is folded into the
// parse state in the cycle it is accepted; the only path is the per-byte
// next-state logic between the state registers and the result register.
// On the last byte a result is registered (skid stage on a stall): accepted
// and message_kind (0 ignored, 1 offer, 2 ack), the bound flag, and the
// stored yiaddr, subnet mask, router, DNS server, server id and lease time.
// An OFFER that matches op 2 and the configured transaction id, and is at
// least 243 bytes long, commits every value it carried; an ACK only sets
// bound. Ignored packets report the values as they stand. Throughput is one
// byte per cycle; in_ready drops only when two finished results are waiting
// on out_ready (the output register and its skid stage are both full).
// transaction_id is written through the cfg channel, which is always
// ready; write it only between packets.
module dhcp_reply_parser_unit import dhcprp_pkg::*; (
  input  logic        clk,
  input  logic        rst,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,

  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_item,

  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_item
);

  logic         [31:0] transaction_id;
  parse_state_t        pstate;
  parse_state_t        pstate_next;
  kind_t               reply_kind;
  slot_vals_t          stored_values;
  slot_vals_t          stored_values_next;
  logic                bound_flag;
  logic                bound_flag_next;
  out_item_t           result;
  logic                skid_valid;
  out_item_t           skid_item;
  logic                in_fire;
  logic                push;
  logic                out_stall;

  assign cfg_ready = 1'b1;
  assign in_ready  = !skid_valid;
  assign in_fire   = in_valid && in_ready;
  assign push      = in_fire && in_item.last_byte;
  assign out_stall = out_valid && !out_ready;

  dhcprp_parse u_parse (
    .cur            (pstate),
    .payload_byte   (in_item.payload_byte),
    .transaction_id (transaction_id),
    .nxt            (pstate_next),
    .reply_kind     (reply_kind)
  );

  // Commit pending values on a good OFFER; any good reply binds.
  always_comb begin
    stored_values_next = stored_values;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (reply_kind == KIND_OFFER && pstate_next.pending_valid[i]) begin
        stored_values_next[i] = pstate_next.pending_values[i];
      end
    end
    bound_flag_next = bound_flag || (reply_kind != KIND_NONE);

    result.accepted      = (reply_kind != KIND_NONE);
    result.message_kind  = reply_kind;
    result.bound         = bound_flag_next;
    result.offered_ip    = stored_values_next[SLOT_IP];
    result.subnet_mask   = stored_values_next[SLOT_MASK];
    result.gateway_ip    = stored_values_next[SLOT_GW];
    result.dns_ip        = stored_values_next[SLOT_DNS];
    result.server_ip     = stored_values_next[SLOT_SERVER];
    result.lease_seconds = stored_values_next[SLOT_LEASE];
  end

  // Control and kept state.
  always_ff @(posedge clk) begin
    if (rst) begin
      transaction_id <= '0;
      pstate         <= PARSE_RESET;
      stored_values  <= '0;
      bound_flag     <= 1'b0;
      out_valid      <= 1'b0;
      skid_valid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        transaction_id <= cfg_data;
      end
      if (in_fire) begin
        if (in_item.last_byte) begin
          // Close the packet: commit and start over.
          pstate        <= PARSE_RESET;
          stored_values <= stored_values_next;
          bound_flag    <= bound_flag_next;
        end else begin
          pstate <= pstate_next;
        end
      end
      if (out_stall) begin
        // Hold the output; park a new result in the skid stage.
        if (push) begin
          skid_valid <= 1'b1;
        end
      end else if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end
  end

  // Result payload registers.
  always_ff @(posedge clk) begin
    if (out_stall) begin
      if (push) begin
        skid_item <= result;
      end
    end else if (skid_valid) begin
      out_item <= skid_item;
    end else if (push) begin
      out_item <= result;
    end
  end

endmodule
